// ----- src/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, suppressed while reset is high.
`define JST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define JST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JST_ASSERT(lbl, clk, rst, prop, msg)
`define JST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- src/jst_pkg.sv -----
// Types, codes and literal tables for the JSON stream tokenizer.
package jst_pkg;

   typedef enum logic [12:0] {
      GP_START       = 13'h0001,
      GP_OBJ_OPEN    = 13'h0002,
      GP_OBJ_KEYDONE = 13'h0004,
      GP_OBJ_COLON   = 13'h0008,
      GP_OBJ_VALUE   = 13'h0010,
      GP_OBJ_COMMA   = 13'h0020,
      GP_ARR_OPEN    = 13'h0040,
      GP_ARR_VALUE   = 13'h0080,
      GP_ARR_COMMA   = 13'h0100,
      GP_STRING      = 13'h0200,
      GP_NUMBER      = 13'h0400,
      GP_LITERAL     = 13'h0800,
      GP_STOP        = 13'h1000
   } gp_type;

   localparam logic [3:0] EV_WS        = 4'd0;
   localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
   localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
   localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
   localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
   localparam logic [3:0] EV_KEY_START = 4'd5;
   localparam logic [3:0] EV_STR_START = 4'd6;
   localparam logic [3:0] EV_STR_CHAR  = 4'd7;
   localparam logic [3:0] EV_STR_END   = 4'd8;
   localparam logic [3:0] EV_COLON     = 4'd9;
   localparam logic [3:0] EV_COMMA     = 4'd10;
   localparam logic [3:0] EV_NUM_CHAR  = 4'd11;
   localparam logic [3:0] EV_LIT_CHAR  = 4'd12;

   localparam logic [2:0] SC_NONE  = 3'd0;
   localparam logic [2:0] SC_INT   = 3'd1;
   localparam logic [2:0] SC_REAL  = 3'd2;
   localparam logic [2:0] SC_TRUE  = 3'd3;

   localparam logic [2:0] NF_INT     = 3'd0;
   localparam logic [2:0] NF_NEG0    = 3'd1;
   localparam logic [2:0] NF_NEGD    = 3'd2;
   localparam logic [2:0] NF_NEGDOT0 = 3'd3;
   localparam logic [2:0] NF_FRAC    = 3'd4;
   localparam logic [2:0] NF_EXP0    = 3'd5;
   localparam logic [2:0] NF_EXPD    = 3'd6;

   localparam logic [1:0] LK_TRUE  = 2'd0;
   localparam logic [1:0] LK_FALSE = 2'd1;
   localparam logic [1:0] LK_NULL  = 2'd2;

   localparam logic [63:0] INT63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ACC_CAP   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ACC_SAFE  = 64'd922337203685477580;

   localparam logic [2:0] CSR_MAX_NESTING = 3'd0;
   localparam logic [5:0] MAX_NESTING_RST = 6'd32;

   typedef struct packed {
      gp_type      gp;
      logic        in_key;
      logic        esc;
      logic [4:0]  lki;
      logic [63:0] acc;
      logic [2:0]  nf;
      logic        err;
   } tok_state_type;

   typedef struct packed {
      logic [3:0]  ev;
      logic [7:0]  chr;
      logic [2:0]  sc;
      logic [62:0] val;
   } tok_result_type;

   function automatic logic [7:0] lit_byte(input logic [1:0] kind, input logic [2:0] pos);
      logic [7:0] b;
      b = 8'h00;
      case ({kind, pos})
         {LK_TRUE, 3'd0}:  b = "t";
         {LK_TRUE, 3'd1}:  b = "r";
         {LK_TRUE, 3'd2}:  b = "u";
         {LK_TRUE, 3'd3}:  b = "e";
         {LK_FALSE, 3'd0}: b = "f";
         {LK_FALSE, 3'd1}: b = "a";
         {LK_FALSE, 3'd2}: b = "l";
         {LK_FALSE, 3'd3}: b = "s";
         {LK_FALSE, 3'd4}: b = "e";
         {LK_NULL, 3'd0}:  b = "n";
         {LK_NULL, 3'd1}:  b = "u";
         {LK_NULL, 3'd2}:  b = "l";
         {LK_NULL, 3'd3}:  b = "l";
         default:          b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] kind);
      logic [2:0] n;
      case (kind)
         LK_TRUE:  n = 3'd4;
         LK_FALSE: n = 3'd5;
         LK_NULL:  n = 3'd4;
         default:  n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- src/jst_csr.sv -----
// Configuration register block: max_nesting behind an APB-style port.
module jst_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [5:0]  max_nesting
);

   logic [5:0] max_nesting_ff;
   logic [5:0] max_nesting_in;
   logic       wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel & csr_penable & csr_pwrite
                   & (csr_paddr == jst_pkg::CSR_MAX_NESTING);

   always_comb begin
      max_nesting_in = max_nesting_ff;
      if (wr_hit) begin
         max_nesting_in = csr_pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_nesting_ff <= jst_pkg::MAX_NESTING_RST;
      end else begin
         max_nesting_ff <= max_nesting_in;
      end
   end

   assign csr_prdata  = (csr_paddr == jst_pkg::CSR_MAX_NESTING) ?
                        {26'd0, max_nesting_ff} : 32'd0;
   assign max_nesting = max_nesting_ff;

endmodule

// ----- src/jst_step.sv -----
// Next-state and result logic for one byte of the tokenizer.
module jst_step #(
   parameter int STACK_DEPTH = 32,
   parameter int SP_W        = 6
) (
   input  jst_pkg::tok_state_type  st_i,
   input  logic [SP_W-1:0]         sp_i,
   input  logic [STACK_DEPTH-1:0]  stk_i,
   input  logic [7:0]              ch,
   input  logic                    restart,
   input  logic [5:0]              max_nesting,
   output jst_pkg::tok_state_type  st_o,
   output logic [SP_W-1:0]         sp_o,
   output logic [STACK_DEPTH-1:0]  stk_o,
   output jst_pkg::tok_result_type res_o
);

   localparam int LW = (SP_W > 6) ? SP_W : 6;

   function automatic jst_pkg::gp_type vdone(input logic nonempty, input logic top_arr);
      jst_pkg::gp_type g;
      if (!nonempty) begin
         g = jst_pkg::GP_STOP;
      end else if (top_arr) begin
         g = jst_pkg::GP_ARR_VALUE;
      end else begin
         g = jst_pkg::GP_OBJ_VALUE;
      end
      return g;
   endfunction

   function automatic logic [63:0] acc_digit(input logic [63:0] a, input logic [3:0] d);
      logic [63:0] n;
      n = (a << 3) + (a << 1) + {60'd0, d};
      if (a > jst_pkg::ACC_SAFE) begin
         return jst_pkg::ACC_CAP;
      end
      return (n > jst_pkg::INT63_MAX) ? jst_pkg::ACC_CAP : n;
   endfunction

   logic [LW-1:0] limit;
   logic [LW-1:0] sp_ext;

   jst_pkg::gp_type gp;
   logic [SP_W-1:0] sp;
   logic [STACK_DEPTH-1:0] stk;
   logic        in_key, esc, err;
   logic [4:0]  lki;
   logic [63:0] acc;
   logic [2:0]  nf;
   logic [3:0]  ev;
   logic [7:0]  chr;
   logic [2:0]  sc;
   logic [62:0] val;
   logic        is_ws, is_dig, num_ch, do_disp, begin_v, close_f, close_arr;
   logic [3:0]  dval;
   logic [1:0]  kind;
   logic [2:0]  pos;

   assign is_ws  = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
   assign is_dig = (ch >= "0") && (ch <= "9");
   assign num_ch = is_dig || (ch == ".") || (ch == "e") || (ch == "E");
   assign dval   = 4'(ch - "0");

   always_comb begin
      limit = (LW'(max_nesting) < LW'(STACK_DEPTH)) ? LW'(max_nesting) : LW'(STACK_DEPTH);
      gp     = restart ? jst_pkg::GP_START : st_i.gp;
      sp     = restart ? '0 : sp_i;
      stk    = restart ? '0 : stk_i;
      in_key = restart ? 1'b0 : st_i.in_key;
      esc    = restart ? 1'b0 : st_i.esc;
      lki    = restart ? 5'd0 : st_i.lki;
      acc    = restart ? 64'd0 : st_i.acc;
      nf     = restart ? jst_pkg::NF_INT : st_i.nf;
      err    = restart ? 1'b0 : st_i.err;
      ev = jst_pkg::EV_WS; chr = 8'd0; sc = jst_pkg::SC_NONE; val = 63'd0;
      do_disp = 1'b0; begin_v = 1'b0; close_f = 1'b0; close_arr = 1'b0;
      kind = lki[4:3];
      pos  = lki[2:0];
      sp_ext = LW'(sp);

      if (!err) begin
         if (gp == jst_pkg::GP_NUMBER) begin
            if (num_ch) begin
               ev = jst_pkg::EV_NUM_CHAR;
               if (is_dig) begin
                  case (nf)
                     jst_pkg::NF_INT:     acc = acc_digit(acc, dval);
                     jst_pkg::NF_NEG0:    nf = jst_pkg::NF_NEGD;
                     jst_pkg::NF_NEGDOT0: nf = jst_pkg::NF_FRAC;
                     jst_pkg::NF_EXP0:    nf = jst_pkg::NF_EXPD;
                     jst_pkg::NF_NEGD, jst_pkg::NF_FRAC, jst_pkg::NF_EXPD: ;
                     default:             err = 1'b1;
                  endcase
               end else if (ch == ".") begin
                  if (nf == jst_pkg::NF_INT || nf == jst_pkg::NF_NEGD) begin
                     nf = jst_pkg::NF_FRAC;
                  end else if (nf == jst_pkg::NF_NEG0) begin
                     nf = jst_pkg::NF_NEGDOT0;
                  end else begin
                     err = 1'b1;
                  end
               end else begin
                  if (nf == jst_pkg::NF_INT || nf == jst_pkg::NF_NEGD
                      || nf == jst_pkg::NF_FRAC) begin
                     nf = jst_pkg::NF_EXP0;
                  end else begin
                     err = 1'b1;
                  end
               end
            end else begin
               // finish the number, then treat this byte as the next token
               if (nf == jst_pkg::NF_INT) begin
                  if (acc > jst_pkg::INT63_MAX) begin
                     err = 1'b1;
                  end else begin
                     sc = jst_pkg::SC_INT;
                     val = acc[62:0];
                  end
               end else if (nf == jst_pkg::NF_NEGD || nf == jst_pkg::NF_FRAC
                            || nf == jst_pkg::NF_EXPD) begin
                  sc = jst_pkg::SC_REAL;
               end else begin
                  err = 1'b1;
               end
               if (!err) begin
                  nf = jst_pkg::NF_INT;
                  acc = 64'd0;
                  gp = vdone(sp != '0, stk[0]);
                  do_disp = 1'b1;
               end
            end
         end else begin
            do_disp = 1'b1;
         end
      end

      if (do_disp) begin
         if (gp == jst_pkg::GP_STRING) begin
            if (esc) begin
               esc = 1'b0;
               if (ch == "u") begin
                  err = 1'b1;
               end else begin
                  ev = jst_pkg::EV_STR_CHAR;
                  case (ch)
                     "b":     chr = 8'h08;
                     "f":     chr = 8'h0C;
                     "n":     chr = 8'h0A;
                     "r":     chr = 8'h0D;
                     "t":     chr = 8'h09;
                     default: chr = ch;
                  endcase
               end
            end else if (ch == "\"") begin
               ev = jst_pkg::EV_STR_END;
               if (in_key) begin
                  in_key = 1'b0;
                  gp = jst_pkg::GP_OBJ_KEYDONE;
               end else begin
                  gp = vdone(sp != '0, stk[0]);
               end
            end else if (ch == "\\") begin
               esc = 1'b1;
            end else begin
               ev = jst_pkg::EV_STR_CHAR;
               chr = ch;
            end
         end else if (gp == jst_pkg::GP_LITERAL) begin
            if (kind > jst_pkg::LK_NULL || pos >= jst_pkg::lit_len(kind)
                || ch != jst_pkg::lit_byte(kind, pos)) begin
               err = 1'b1;
            end else begin
               ev = jst_pkg::EV_LIT_CHAR;
               pos = pos + 3'd1;
               lki = {kind, pos};
               if (pos == jst_pkg::lit_len(kind)) begin
                  sc = jst_pkg::SC_TRUE + {1'b0, kind};
                  lki = 5'd0;
                  gp = vdone(sp != '0, stk[0]);
               end
            end
         end else if (is_ws) begin
            ev = jst_pkg::EV_WS;
         end else begin
            case (gp)
               jst_pkg::GP_START, jst_pkg::GP_OBJ_COLON, jst_pkg::GP_ARR_COMMA: begin
                  begin_v = 1'b1;
               end
               jst_pkg::GP_ARR_OPEN: begin
                  if (ch == "]") begin
                     close_f = 1'b1; close_arr = 1'b1;
                  end else begin
                     begin_v = 1'b1;
                  end
               end
               jst_pkg::GP_OBJ_OPEN, jst_pkg::GP_OBJ_COMMA: begin
                  if (ch == "\"") begin
                     in_key = 1'b1; esc = 1'b0;
                     gp = jst_pkg::GP_STRING;
                     ev = jst_pkg::EV_KEY_START;
                  end else if (ch == "}" && gp == jst_pkg::GP_OBJ_OPEN) begin
                     close_f = 1'b1;
                  end else begin
                     err = 1'b1;
                  end
               end
               jst_pkg::GP_OBJ_KEYDONE: begin
                  if (ch == ":") begin
                     gp = jst_pkg::GP_OBJ_COLON;
                     ev = jst_pkg::EV_COLON;
                  end else begin
                     err = 1'b1;
                  end
               end
               jst_pkg::GP_OBJ_VALUE: begin
                  if (ch == ",") begin
                     gp = jst_pkg::GP_OBJ_COMMA;
                     ev = jst_pkg::EV_COMMA;
                  end else if (ch == "}") begin
                     close_f = 1'b1;
                  end else begin
                     err = 1'b1;
                  end
               end
               jst_pkg::GP_ARR_VALUE: begin
                  if (ch == ",") begin
                     gp = jst_pkg::GP_ARR_COMMA;
                     ev = jst_pkg::EV_COMMA;
                  end else if (ch == "]") begin
                     close_f = 1'b1; close_arr = 1'b1;
                  end else begin
                     err = 1'b1;
                  end
               end
               default: err = 1'b1;
            endcase
         end
      end

      if (close_f) begin
         if (sp != '0) begin
            sp  = sp - SP_W'(1);
            stk = {1'b0, stk[STACK_DEPTH-1:1]};
         end
         ev = close_arr ? jst_pkg::EV_ARR_CLOSE : jst_pkg::EV_OBJ_CLOSE;
         gp = vdone(sp != '0, stk[0]);
      end

      if (begin_v) begin
         if (ch == "\"") begin
            in_key = 1'b0; esc = 1'b0;
            gp = jst_pkg::GP_STRING;
            ev = jst_pkg::EV_STR_START;
         end else if (ch == "{" || ch == "[") begin
            if (sp_ext >= limit) begin
               err = 1'b1;
            end else begin
               stk = {stk[STACK_DEPTH-2:0], (ch == "[")};
               sp  = sp + SP_W'(1);
               gp  = (ch == "[") ? jst_pkg::GP_ARR_OPEN : jst_pkg::GP_OBJ_OPEN;
               ev  = (ch == "[") ? jst_pkg::EV_ARR_OPEN : jst_pkg::EV_OBJ_OPEN;
            end
         end else if (ch == "t" || ch == "f" || ch == "n") begin
            lki = {(ch == "t") ? jst_pkg::LK_TRUE :
                   ((ch == "f") ? jst_pkg::LK_FALSE : jst_pkg::LK_NULL), 3'd1};
            gp = jst_pkg::GP_LITERAL;
            ev = jst_pkg::EV_LIT_CHAR;
         end else if (is_dig || ch == "-") begin
            if (ch == "-") begin
               nf = jst_pkg::NF_NEG0;
               acc = 64'd0;
            end else begin
               nf = jst_pkg::NF_INT;
               acc = {60'd0, dval};
            end
            gp = jst_pkg::GP_NUMBER;
            ev = jst_pkg::EV_NUM_CHAR;
         end else begin
            err = 1'b1;
         end
      end

      if (err) begin
         ev = jst_pkg::EV_WS; chr = 8'd0; sc = jst_pkg::SC_NONE; val = 63'd0;
      end

      st_o.gp = gp; st_o.in_key = in_key; st_o.esc = esc; st_o.lki = lki;
      st_o.acc = acc; st_o.nf = nf; st_o.err = err;
      sp_o  = sp;
      stk_o = stk;
      res_o.ev = ev; res_o.chr = chr; res_o.sc = sc; res_o.val = val;
   end

endmodule

// ----- src/json_stream_tokenizer_top.sv -----
// Top level of the JSON stream tokenizer: state registers, result register, CSR.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_ch, req_restart
//  rsp     | out       | rsp_valid/rsp_stall  | event, char, scalar, value, depth, flags
//  csr     | in/out    | APB psel/penable     | max_nesting at byte address 0
//
// One byte per cycle while the output side does not stall: the parser state and
// the item's result both load at the accepting edge, so the result is offered in
// the cycle after; the integer accumulate is a times-ten add and compare.
// Synchronous reset clears all parser state and sets max_nesting to 32.
// The input stalls only while a result is held and the output side stalls.
`include "assert_macros.svh"
module json_stream_tokenizer_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_res,
   output logic [7:0]  rsp_out_char,
   output logic [2:0]  rsp_scalar_done,
   output logic [62:0] rsp_int_value,
   output logic [5:0]  rsp_depth,
   output logic        rsp_error,
   output logic        rsp_accepted,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);

   logic [5:0] max_nesting;

   // parser state
   jst_pkg::tok_state_type st_ff, st_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic [STACK_DEPTH-1:0] stk_ff, stk_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   jst_pkg::tok_result_type res_ff, res_in;
   logic [5:0]              depth_ff, depth_in;
   logic                    err_ff, err_in;
   logic                    acc_ff, acc_in;

   jst_pkg::tok_state_type  st_nx;
   logic [SP_W-1:0]         sp_nx;
   logic [STACK_DEPTH-1:0]  stk_nx;
   jst_pkg::tok_result_type res_nx;
   logic                    take;

   jst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_nesting (max_nesting)
   );

   jst_step #(
      .STACK_DEPTH (STACK_DEPTH),
      .SP_W        (SP_W)
   ) u_step (
      .st_i        (st_ff),
      .sp_i        (sp_ff),
      .stk_i       (stk_ff),
      .ch          (req_ch),
      .restart     (req_restart),
      .max_nesting (max_nesting),
      .st_o        (st_nx),
      .sp_o        (sp_nx),
      .stk_o       (stk_nx),
      .res_o       (res_nx)
   );

   // hold the input only while a result waits and the far side is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      st_in  = st_ff;
      sp_in  = sp_ff;
      stk_in = stk_ff;
      res_in = res_ff;
      depth_in = depth_ff;
      err_in = err_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (take) begin
         // advance the parser and capture this item's result
         st_in  = st_nx;
         sp_in  = sp_nx;
         stk_in = stk_nx;
         res_in = res_nx;
         depth_in = 6'(sp_nx);
         err_in = st_nx.err;
         acc_in = (st_nx.gp == jst_pkg::GP_STOP) & ~st_nx.err;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.gp     <= jst_pkg::GP_START;
         st_ff.in_key <= 1'b0;
         st_ff.esc    <= 1'b0;
         st_ff.lki    <= 5'd0;
         st_ff.acc    <= 64'd0;
         st_ff.nf     <= jst_pkg::NF_INT;
         st_ff.err    <= 1'b0;
         sp_ff        <= '0;
         stk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         sp_ff        <= sp_in;
         stk_ff       <= stk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result fields are only looked at while rsp_valid is high, so no reset is needed
   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      depth_ff <= depth_in;
      err_ff   <= err_in;
      acc_ff   <= acc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = res_ff.ev;
   assign rsp_out_char    = res_ff.chr;
   assign rsp_scalar_done = res_ff.sc;
   assign rsp_int_value   = res_ff.val;
   assign rsp_depth       = depth_ff;
   assign rsp_error       = err_ff;
   assign rsp_accepted    = acc_ff;

   `JST_ASSERT(a_err_sticky, clock, reset, (take && st_ff.err && !req_restart) |=> st_ff.err, "error flag dropped without restart")
   `JST_ASSERT(a_sp_bound, clock, reset, (sp_ff <= SP_W'(STACK_DEPTH)), "stack pointer past stack depth")
   `JST_ASSERT(a_acc_no_err, clock, reset, rsp_valid_ff |-> !(acc_ff && err_ff), "document accepted with error set")
   `JST_ASSERT_ALWAYS(a_stall_src, clock, req_stall |-> rsp_valid_ff, "input stalled with no result held")

endmodule
